>>> hdl/rppd_pkg.sv
// rppd_pkg: shared widths, codes, reset values and controller/datapath structs
// for the PPM pulse decoder. No dependencies.
package rppd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int MAX_RESULTS      = 8;

    localparam int TIME_W   = 16;
    localparam int PERIOD_W = 17;
    localparam int RLEN_W   = 4;
    localparam int CHNUM_W  = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [TIME_W-1:0]   SYNC_THRESHOLD_RST = 16'd2500;
    localparam logic [PERIOD_W-1:0] COUNTER_PERIOD_RST = 17'h10000;

    // register select is address bit 2 (registers at 0x0 and 0x4)
    localparam logic REG_SYNC_THRESHOLD = 1'b0;
    localparam logic REG_COUNTER_PERIOD = 1'b1;

    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef struct packed {
        logic latch_in;
        logic calc_span;
        logic apply_span;
        logic start_read;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cmd_read;
        logic frame_ready;
        logic count_zero;
        logic last_word;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hdl/rppd_if.sv
// rppd_in_if / rppd_out_if: valid-ready channels for input and result words.
// Depends on rppd_pkg for field widths.
interface rppd_in_if import rppd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TIME_W-1:0] capture_time;
    logic [RLEN_W-1:0] read_length;

    modport source (output valid, cmd, capture_time, read_length, input ready);
    modport sink   (input valid, cmd, capture_time, read_length, output ready);
endinterface

interface rppd_out_if import rppd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHNUM_W-1:0] channel_number;
    logic [TIME_W-1:0]  channel_width;
    logic               last_of_frame;

    modport source (output valid, channel_number, channel_width, last_of_frame,
                    input ready);
    modport sink   (input valid, channel_number, channel_width, last_of_frame,
                    output ready);
endinterface

>>> hdl/rc_ppm_pulse_decoder_core.sv
// rc_ppm_pulse_decoder_core: top level of the radio-control PPM decoder.
// Capture word: accepted in IDLE, its interval computed in DECODE and stored in APPLY.
// Read word: decoded in DECODE, then results are loaded in EMIT, one per cycle while the
// sink is ready; a read that emits nothing goes from DECODE straight back to IDLE.
// The next word is taken the cycle after the last result is queued; one word at a time.
// Reset (synchronous, active low) clears the store, indexes, ready flag and output valid.
module rc_ppm_pulse_decoder_core import rppd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rppd_in_if.sink           i_in,
    rppd_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [TIME_W-1:0]   r_sync_threshold;
    logic [PERIOD_W-1:0] r_counter_period;

    t_ctrl_cmd ctrl_cmd;
    t_dp_sts   dp_sts;
    logic      in_ready;
    logic      cfg_write;
    logic      reg_sel;

    // Zero-wait APB: a write lands on the access phase. Address bit 2 picks the
    // register; the low bits are ignored.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_threshold <= SYNC_THRESHOLD_RST;
            r_counter_period <= COUNTER_PERIOD_RST;
        end else if (cfg_write) begin
            if (reg_sel == REG_SYNC_THRESHOLD) begin
                r_sync_threshold <= pwdata[TIME_W-1:0];
            end else begin
                r_counter_period <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    // read back the selected register, zero-extended
    always_comb begin
        if (reg_sel == REG_COUNTER_PERIOD) begin
            prdata = APB_DW'(r_counter_period);
        end else begin
            prdata = APB_DW'(r_sync_threshold);
        end
    end

    assign i_in.ready = in_ready;

    // sequencer: accepts a word only when idle, steps the datapath through it
    rppd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    // datapath: interval math, channel store and the result register that
    // decouples the sink from the sequencer
    rppd_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (ctrl_cmd),
        .o_sts            (dp_sts),
        .i_sync_threshold (r_sync_threshold),
        .i_counter_period (r_counter_period),
        .i_cmd_bit        (i_in.cmd),
        .i_capture_time   (i_in.capture_time),
        .i_read_length    (i_in.read_length),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_channel_number (o_out.channel_number),
        .o_channel_width  (o_out.channel_width),
        .o_last_of_frame  (o_out.last_of_frame)
    );

endmodule

>>> hdl/rppd_ctrl.sv
// rppd_ctrl: one-hot sequencer for the PPM decoder; drives datapath commands.
// Depends on rppd_pkg (t_ctrl_cmd, t_dp_sts).
module rppd_ctrl import rppd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_sts   i_sts,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_APPLY  = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.cmd_read) begin
                    if (i_sts.frame_ready) begin
                        o_cmd.start_read = 1'b1;
                        n_state = i_sts.count_zero ? S_IDLE : S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.calc_span = 1'b1;
                    n_state         = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply_span = 1'b1;
                n_state          = S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_word) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // no item taken while a burst is being emitted
    a_no_accept_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> !o_in_ready)
        else $error("input accepted during emit");

    // a read decode that starts a burst with words moves on to emitting
    a_read_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_read && !i_sts.count_zero |=> r_state == S_EMIT)
        else $error("burst start did not enter emit");

    // a capture always gets its store/update step next
    a_span_then_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.calc_span |=> o_cmd.apply_span)
        else $error("span computed without apply");

endmodule

>>> hdl/rppd_dp.sv
// rppd_dp: PPM decoder datapath: input latch, interval math, channel store,
// frame bookkeeping and the output register. Depends on rppd_pkg.
module rppd_dp import rppd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_dp_sts             o_sts,
    input  logic [TIME_W-1:0]   i_sync_threshold,
    input  logic [PERIOD_W-1:0] i_counter_period,
    input  logic                i_cmd_bit,
    input  logic [TIME_W-1:0]   i_capture_time,
    input  logic [RLEN_W-1:0]   i_read_length,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [CHNUM_W-1:0]  o_channel_number,
    output logic [TIME_W-1:0]   o_channel_width,
    output logic                o_last_of_frame
);

    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int BURST  = (MAX_CHANNELS < MAX_RESULTS) ? MAX_CHANNELS : MAX_RESULTS;
    localparam logic [RLEN_W-1:0] BURST_MAX = RLEN_W'(BURST);
    localparam logic [NCH_W-1:0]  NCH_MAX   = NCH_W'(MAX_CHANNELS);

    logic                r_cmd;
    logic [TIME_W-1:0]   r_time;
    logic [RLEN_W-1:0]   r_rlen;
    logic [TIME_W-1:0]   r_prev;
    logic [TIME_W-1:0]   r_span;
    logic [NCH_W-1:0]    r_next_ch;
    logic                r_frame_ready;
    logic [TIME_W-1:0]   r_store [MAX_CHANNELS];
    logic [RLEN_W-1:0]   r_count;
    logic [CHNUM_W-1:0]  r_k;
    logic                r_out_valid;
    logic [CHNUM_W-1:0]  r_out_num;
    logic [TIME_W-1:0]   r_out_width;
    logic                r_out_last;

    logic [TIME_W-1:0]   n_span;
    logic [RLEN_W-1:0]   n_count;
    logic                last_word;
    logic                out_free;

    // low period bits suffice: the interval is kept modulo 2^16
    always_comb begin
        if (r_time < r_prev) begin
            n_span = r_time - r_prev + i_counter_period[TIME_W-1:0];
        end else begin
            n_span = r_time - r_prev;
        end
    end

    assign n_count   = (r_rlen > BURST_MAX) ? BURST_MAX : r_rlen;
    assign last_word = (RLEN_W'(r_k) + RLEN_W'(1)) == r_count;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.cmd_read    = (r_cmd == CMD_READ);
        o_sts.frame_ready = r_frame_ready;
        o_sts.count_zero  = (r_rlen == '0);
        o_sts.last_word   = last_word;
        o_sts.out_free    = out_free;
    end

    // latched item and span: payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd  <= i_cmd_bit;
            r_time <= i_capture_time;
            r_rlen <= i_read_length;
        end
        if (i_cmd.calc_span) begin
            r_span <= n_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_next_ch     <= '0;
            r_frame_ready <= 1'b0;
            r_count       <= '0;
            r_k           <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (i_cmd.calc_span) begin
                r_prev <= r_time;
            end
            if (i_cmd.apply_span) begin
                if (r_span > i_sync_threshold) begin
                    r_next_ch     <= '0;
                    r_frame_ready <= 1'b1;
                end else if (r_next_ch < NCH_MAX) begin
                    r_store[IDX_W'(r_next_ch)] <= r_span;
                    r_next_ch <= r_next_ch + NCH_W'(1);
                end
            end
            if (i_cmd.start_read) begin
                r_frame_ready <= 1'b0;
                r_count       <= n_count;
                r_k           <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_k         <= r_k + CHNUM_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_num   <= r_k;
            r_out_width <= r_store[IDX_W'(r_k)];
            r_out_last  <= last_word;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_channel_number = r_out_num;
    assign o_channel_width  = r_out_width;
    assign o_last_of_frame  = r_out_last;

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("word loaded over an untaken word");

    a_ready_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_read |=> !r_frame_ready)
        else $error("frame ready not cleared by read");

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_ch <= NCH_MAX)
        else $error("channel index past end");

endmodule
